@@ design/dq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the double-ended queue.
// Used by dq_ctrl and double_ended_queue_core; no dependencies.
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int TDATA_IN_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RES_W      = 3 * DATA_WIDTH + CNT_W + 3;
    localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;
    typedef logic [CNT_W:0]               t_sum;

    typedef struct packed {
        logic  overflow;
        logic  underflow;
        logic  is_empty;
        t_cnt  element_count;
        t_data rear_value;
        t_data front_value;
        t_data popped_value;
    } t_result;

    // base + ofs modulo DEPTH, valid while base < DEPTH and ofs < DEPTH
    function automatic t_idx wrap_add(input t_idx base, input t_cnt ofs);
        t_sum s;
        s = t_sum'(base) + t_sum'(ofs);
        if (s >= t_sum'(DEPTH)) begin
            s = s - t_sum'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic t_idx wrap_inc(input t_idx i);
        return (i == t_idx'(DEPTH - 1)) ? '0 : i + t_idx'(1);
    endfunction

    function automatic t_idx wrap_dec(input t_idx i);
        return (i == '0) ? t_idx'(DEPTH - 1) : i - t_idx'(1);
    endfunction

endpackage

@@ design/dq_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW_P-1:0]    i_wr_addr,
    input  logic [WIDTH_P-1:0] i_wr_data,
    input  logic [AW_P-1:0]    i_rd_addr,
    output logic [WIDTH_P-1:0] o_rd_data
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/dq_ctrl.sv @@
`timescale 1ns / 1ps
// Queue control: head index, count, cached front/rear values and the slot RAM.
// Depends on dq_pkg and dq_ram.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [CMD_W-1:0] i_command,
    input  t_data            i_push_value,
    output logic             o_busy,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic  r_state, n_state;
    t_idx  r_head, n_head;
    t_cnt  r_count, n_count;
    t_data r_front, n_front;
    t_data r_rear, n_rear;
    logic  r_fetch_front, n_fetch_front;
    t_data r_pop_val;

    logic  mem_wr_en;
    t_idx  mem_wr_addr;
    t_idx  mem_rd_addr;
    t_data mem_rd_data;

    t_data popped;
    logic  under;
    logic  over;
    logic  full;
    logic  empty;

    assign full  = (r_count == t_cnt'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_front       = r_front;
        n_rear        = r_rear;
        n_fetch_front = r_fetch_front;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_head;
        mem_rd_addr   = r_head;
        popped        = '0;
        under         = 1'b0;
        over          = 1'b0;
        o_res_valid   = 1'b0;

        if (r_state == ST_FETCH) begin
            // refill the cached end from the RAM read issued last cycle
            o_res_valid = 1'b1;
            n_state     = ST_IDLE;
            popped      = r_pop_val;
            if (r_fetch_front) begin
                n_front = mem_rd_data;
            end else begin
                n_rear = mem_rd_data;
            end
        end else if (i_accept) begin
            unique case (i_command)
                CMD_PUSH_FRONT: begin
                    o_res_valid = 1'b1;
                    if (full) begin
                        over = 1'b1;
                    end else begin
                        n_head      = wrap_dec(r_head);
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wrap_dec(r_head);
                        n_front     = i_push_value;
                        if (empty) begin
                            n_rear = i_push_value;
                        end
                        n_count = r_count + t_cnt'(1);
                    end
                end
                CMD_PUSH_BACK: begin
                    o_res_valid = 1'b1;
                    if (full) begin
                        over = 1'b1;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wrap_add(r_head, r_count);
                        n_rear      = i_push_value;
                        if (empty) begin
                            n_front = i_push_value;
                        end
                        n_count = r_count + t_cnt'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (empty) begin
                        o_res_valid = 1'b1;
                        under       = 1'b1;
                    end else begin
                        popped  = r_front;
                        n_head  = wrap_inc(r_head);
                        n_count = r_count - t_cnt'(1);
                        if (r_count == t_cnt'(2)) begin
                            o_res_valid = 1'b1;
                            n_front     = r_rear;
                        end else if (r_count == t_cnt'(1)) begin
                            o_res_valid = 1'b1;
                        end else begin
                            mem_rd_addr   = wrap_inc(r_head);
                            n_fetch_front = 1'b1;
                            n_state       = ST_FETCH;
                        end
                    end
                end
                CMD_POP_BACK: begin
                    if (empty) begin
                        o_res_valid = 1'b1;
                        under       = 1'b1;
                    end else begin
                        popped  = r_rear;
                        n_count = r_count - t_cnt'(1);
                        if (r_count == t_cnt'(2)) begin
                            o_res_valid = 1'b1;
                            n_rear      = r_front;
                        end else if (r_count == t_cnt'(1)) begin
                            o_res_valid = 1'b1;
                        end else begin
                            // new rear sits at head + (count - 2)
                            mem_rd_addr   = wrap_add(r_head, r_count - t_cnt'(2));
                            n_fetch_front = 1'b0;
                            n_state       = ST_FETCH;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res.popped_value  = popped;
        o_res.element_count = n_count;
        o_res.is_empty      = (n_count == '0);
        o_res.front_value   = (n_count == '0) ? '1 : n_front;
        o_res.rear_value    = (n_count == '0) ? '1 : n_rear;
        o_res.underflow     = under;
        o_res.overflow      = over;
    end

    assign o_busy = (r_state == ST_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front       <= n_front;
        r_rear        <= n_rear;
        r_fetch_front <= n_fetch_front;
        if (i_accept) begin
            r_pop_val <= popped;
        end
    end

    dq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

@@ design/double_ended_queue_core.sv @@
`timescale 1ns / 1ps
// Double-ended queue: a DEPTH-entry ring buffer in one synchronous RAM, with
// the front and rear elements cached in registers so that every command
// reports both ends at once. Pushes (dropped or not), pops on an empty queue
// and pops that leave at most one element give their result directly; a pop
// that leaves two or more goes through a fetch state that reads the new end
// element from the RAM (one read port, registered read data). Each item gets
// one result item, held in an output register; the input stalls while that
// register holds a result that has not been taken, unless it leaves in the
// same cycle, and while a pop waits for its RAM read. A push to a full queue
// is dropped and flagged as overflow; a pop on an empty queue returns 0 and
// flags underflow. Front and rear read as all ones when empty.
// Depends on dq_pkg and dq_ctrl.
module double_ended_queue_core
    import dq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,  // push_value
    input  logic [CMD_W-1:0]       i_s_axis_tuser,  // command
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // popped_value, front_value, rear_value, element_count, is_empty,
    // underflow, overflow
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata
);

    logic    accept;
    logic    busy;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign o_s_axis_tready = !busy && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    dq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_s_axis_tuser),
        .i_push_value (t_data'(i_s_axis_tdata[DATA_WIDTH-1:0])),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_OUT_W'(r_out);

endmodule
